FILE: rtl/tsp_pkg.sv
// shared constants and types for the trapezoid step planner
`timescale 1ns / 1ps
package tsp_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] cmd_type;

   localparam phase_type PH_ACCEL = 3'd0;
   localparam phase_type PH_SLEW  = 3'd1;
   localparam phase_type PH_DECEL = 3'd2;
   localparam phase_type PH_STOP  = 3'd3;
   localparam phase_type PH_STALL = 3'd4;

   localparam cmd_type CMD_START   = 2'd0;
   localparam cmd_type CMD_ADVANCE = 2'd1;
   localparam cmd_type CMD_STOP    = 2'd2;
   localparam cmd_type CMD_STALL   = 2'd3;

   localparam logic REG_ENDSTOP  = 1'b0;
   localparam logic REG_STALL_EN = 1'b1;

   // serial unit widths
   localparam int DIV_W    = 64;
   localparam int MUL_A_W  = 33;
   localparam int MUL_B_W  = 64;
   localparam int SQRT_IN_W  = 64;
   localparam int SQRT_OUT_W = 32;

endpackage

FILE: rtl/tsp_div.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tsp_div
   import tsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [DIV_W-1:0] quot
);
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;
   logic [DIV_W:0]   shifted, diff;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cnt_ff != '0) begin
         rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end else if (start) begin
         rem_in = '0;
         quo_in = num;
         den_in = den;
         cnt_in = CNT_W'(DIV_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
endmodule

FILE: rtl/tsp_mul.sv
// bit-serial saturating multiplier, msb of a first
`timescale 1ns / 1ps
module tsp_mul
   import tsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic               done,
   output logic [MUL_B_W-1:0] prod
);
   localparam int CNT_W = $clog2(MUL_A_W + 1);

   logic [MUL_A_W-1:0] a_ff, a_in;
   logic [MUL_B_W-1:0] b_ff, b_in, acc_ff, acc_in;
   logic               sat_ff, sat_in, done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MUL_B_W:0]   sum;

   always_comb begin
      sum = {1'b0, acc_ff[MUL_B_W-2:0], 1'b0}
          + (a_ff[MUL_A_W-1] ? {1'b0, b_ff} : '0);
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cnt_ff != '0) begin
         a_in    = {a_ff[MUL_A_W-2:0], 1'b0};
         acc_in  = sum[MUL_B_W-1:0];
         // partial products only grow, so an overflow sticks
         sat_in  = sat_ff | acc_ff[MUL_B_W-1] | sum[MUL_B_W];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end else if (start) begin
         a_in   = a;
         b_in   = b;
         acc_in = '0;
         sat_in = 1'b0;
         cnt_in = CNT_W'(MUL_A_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign prod = sat_ff ? '1 : acc_ff;
endmodule

FILE: rtl/tsp_sqrt.sv
// digit-by-digit integer square root, one root bit per cycle
`timescale 1ns / 1ps
module tsp_sqrt
   import tsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SQRT_IN_W-1:0]  rad,
   output logic                  done,
   output logic [SQRT_OUT_W-1:0] root
);
   localparam int CNT_W = $clog2(SQRT_OUT_W + 1);
   localparam int REM_W = SQRT_OUT_W + 3;

   logic [SQRT_IN_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in, r4, trial;
   logic [SQRT_OUT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in, ge;

   always_comb begin
      r4      = {rem_ff[REM_W-3:0], rad_ff[SQRT_IN_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      ge      = r4 >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (cnt_ff != '0) begin
         rad_in  = {rad_ff[SQRT_IN_W-3:0], 2'b00};
         rem_in  = ge ? r4 - trial : r4;
         root_in = {root_ff[SQRT_OUT_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end else if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(SQRT_OUT_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

FILE: rtl/trapezoid_step_planner_core.sv
// top level of the trapezoid step planner: sequencer, axis state and ports
`timescale 1ns / 1ps
// One command word in, one response word out. Commands are taken one at a time
// (req_stall is high from acceptance until the response is registered). Stop, stall
// and an advance that plans nothing go only through dispatch; an advance that plans
// a step runs the multiplier and, in accel or decel, the square root; a start works
// out the inverses, accel distance and three segment times, then plans the first
// step. Once the response is registered the next command can be taken. Three shared
// serial units each retire one bit per cycle: a 64-step restoring divider (run three
// times on a start), a 33-step saturating multiplier (run for the speed square, each
// segment time and each planned step) and a 32-step square root (run for the first
// and last segment times and each accel or decel step). Positions wrap in POS_BITS,
// fixed-point inverses carry FRAC_BITS fraction bits. A response that is stalled
// holds in the output register while the next command is already accepted; its own
// response then waits for the register to free.
module trapezoid_step_planner_core
   import tsp_pkg::*;
#(
   parameter int POS_BITS  = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // command word
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic signed [31:0] req_target_steps,
   input  logic [31:0] req_speed,
   input  logic [31:0] req_accel,
   input  logic        req_apply_limit,
   input  logic [31:0] req_start_delay_ticks,
   input  logic [31:0] req_now_ticks,
   // response word
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_step_due,
   output logic [31:0] rsp_next_time,
   output logic [2:0]  rsp_phase,
   output logic        rsp_step_pulse,
   output logic        rsp_direction,
   output logic signed [31:0] rsp_position,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_PREP   = 4'd2;
   localparam logic [3:0] S_DIV_IS = 4'd3;
   localparam logic [3:0] S_DIV_IA = 4'd4;
   localparam logic [3:0] S_MUL_SQ = 4'd5;
   localparam logic [3:0] S_DIV_D1 = 4'd6;
   localparam logic [3:0] S_ADJ    = 4'd7;
   localparam logic [3:0] S_JMUL   = 4'd8;
   localparam logic [3:0] S_JSQRT  = 4'd9;
   localparam logic [3:0] S_JFIN   = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   // which time the multiply/root job is working out
   localparam logic [1:0] J_T1   = 2'd0;
   localparam logic [1:0] J_T2   = 2'd1;
   localparam logic [1:0] J_T3   = 2'd2;
   localparam logic [1:0] J_PLAN = 2'd3;

   localparam logic [63:0] INV_S_NUM  = 64'd1 << (24 + FRAC_BITS);
   localparam logic [63:0] INV_HA_NUM = 64'd1 << (33 + FRAC_BITS);
   localparam logic [63:0] INV_S_MAX  = (64'd1 << 48) - 64'd1;
   localparam logic signed [32:0] POS_HI = 33'((64'd1 << (POS_BITS - 1)) - 64'd1);
   localparam logic signed [32:0] POS_LO = -POS_HI - 33'sd1;

   // control
   logic [3:0]  state_ff, state_in;
   logic        launch_ff, launch_in;
   logic [1:0]  job_ff, job_in;
   // captured command
   logic [1:0]  cmd_ff, cmd_in;
   logic signed [POS_BITS-1:0] tgt_ff, tgt_in;
   logic [31:0] spd_ff, spd_in, acc_ff, acc_in, tmp_t_ff, tmp_t_in;
   // registers
   logic [30:0] endstop_ff, endstop_in;
   logic        stall_en_ff, stall_en_in;
   // axis and profile state
   logic signed [POS_BITS-1:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic [32:0] step_ff, step_in;
   logic [31:0] d1_ff, d1_in, d2_ff, d2_in, d3_ff, d3_in;
   logic [31:0] t0_ff, t0_in, t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in;
   logic [47:0] inv_s_ff, inv_s_in;
   logic [63:0] inv_ha_ff, inv_ha_in;
   logic        dir_ff, dir_in, pend_ff, pend_in, pulse_ff, pulse_in;
   logic [31:0] sched_ff, sched_in;
   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_ready_ff, rsp_ready_in, rsp_pulse_ff, rsp_pulse_in;
   logic        rsp_dir_ff, rsp_dir_in;
   logic [31:0] rsp_time_ff, rsp_time_in;
   phase_type   rsp_phase_ff, rsp_phase_in;
   logic signed [31:0] rsp_pos_ff, rsp_pos_in;

   // serial units
   logic              div_start, div_done, mul_start, mul_done, sqrt_start, sqrt_done;
   logic [DIV_W-1:0]  div_num, div_den, div_quot;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b, mul_prod;
   logic [SQRT_IN_W-1:0] sqrt_rad;
   logic [SQRT_OUT_W-1:0] sqrt_root;

   // job decode
   logic        job_root, job_round, job_sub;
   logic [32:0] job_n;
   logic [31:0] job_base, job_r, plan_t;
   logic [32:0] root_plus;

   // start decode
   logic signed [32:0] tsat, diff;
   logic               cfg_wr;

   assign cfg_wr = psel && penable && pwrite && pready;

   always_comb begin
      job_round = (job_ff != J_PLAN);
      job_root  = 1'b1;
      job_sub   = 1'b0;
      job_base  = t0_ff;
      job_n     = {1'b0, d1_ff};
      case (job_ff)
         J_T1: begin
            job_n    = {1'b0, d1_ff};
            job_base = t0_ff;
         end
         J_T2: begin
            job_n    = {1'b0, d2_ff} - {1'b0, d1_ff} + 33'd1;
            job_root = 1'b0;
            job_base = t1_ff;
         end
         J_T3: begin
            job_n    = (d3_ff > d2_ff) ? {1'b0, d3_ff - d2_ff - 32'd1} : '0;
            job_base = t2_ff;
         end
         default: begin
            // the step currently being planned
            case (phase_ff)
               PH_ACCEL: begin
                  job_n    = step_ff;
                  job_base = t0_ff;
               end
               PH_SLEW: begin
                  job_n    = (step_ff >= {1'b0, d1_ff}) ? step_ff - {1'b0, d1_ff} : '0;
                  job_root = 1'b0;
                  job_base = t1_ff;
               end
               default: begin
                  job_n    = ({1'b0, d3_ff} >= step_ff) ? {1'b0, d3_ff} - step_ff : '0;
                  job_base = t3_ff;
                  job_sub  = 1'b1;
               end
            endcase
         end
      endcase

      root_plus = {1'b0, sqrt_root} + 33'd1;
      if (job_root) begin
         job_r = job_round ? root_plus[32:1] : sqrt_root;
      end else begin
         job_r = mul_prod[FRAC_BITS +: 32]
               + (job_round ? {31'd0, mul_prod[FRAC_BITS-1]} : 32'd0);
      end
      plan_t = job_sub ? job_base - job_r : job_base + job_r;
   end

   // unit operands
   always_comb begin
      div_num = INV_S_NUM;
      div_den = {32'd0, spd_ff};
      case (state_ff)
         S_DIV_IA: begin
            div_num = INV_HA_NUM;
            div_den = {32'd0, acc_ff};
         end
         S_DIV_D1: begin
            div_num = mul_prod;
            div_den = {15'd0, acc_ff, 17'd0};
         end
         default: begin
            div_num = INV_S_NUM;
            div_den = {32'd0, spd_ff};
         end
      endcase
      div_start = launch_ff && (state_ff == S_DIV_IS || state_ff == S_DIV_IA
                                || state_ff == S_DIV_D1);
      mul_start = launch_ff && (state_ff == S_MUL_SQ || state_ff == S_JMUL);
      if (state_ff == S_MUL_SQ) begin
         mul_a = {1'b0, spd_ff};
         mul_b = {32'd0, spd_ff};
      end else begin
         mul_a = job_n;
         mul_b = job_root ? inv_ha_ff : {16'd0, inv_s_ff};
      end
      sqrt_start = launch_ff && (state_ff == S_JSQRT);
      sqrt_rad   = job_round ? (mul_prod >> (FRAC_BITS - 2)) : (mul_prod >> FRAC_BITS);
   end

   // target clamp at acceptance
   always_comb begin
      tsat = 33'(req_target_steps);
      if (req_apply_limit) begin
         if (tsat < 33'sd0) tsat = 33'sd0;
         if (tsat > $signed({2'b00, endstop_ff})) tsat = $signed({2'b00, endstop_ff});
      end
      if (tsat < POS_LO) tsat = POS_LO;
      if (tsat > POS_HI) tsat = POS_HI;
      diff = 33'(tgt_ff) - 33'(pos_ff);
   end

   // sequencer and state update
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      cmd_in    = cmd_ff;
      tgt_in    = tgt_ff;
      spd_in    = spd_ff;
      acc_in    = acc_ff;
      tmp_t_in  = tmp_t_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      d1_in     = d1_ff;
      d2_in     = d2_ff;
      d3_in     = d3_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      t2_in     = t2_ff;
      t3_in     = t3_ff;
      inv_s_in  = inv_s_ff;
      inv_ha_in = inv_ha_ff;
      dir_in    = dir_ff;
      pend_in   = pend_ff;
      sched_in  = sched_ff;
      pulse_in  = pulse_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ready_in = rsp_ready_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_pos_in   = rsp_pos_ff;

      endstop_in  = endstop_ff;
      stall_en_in = stall_en_ff;
      if (cfg_wr) begin
         if (paddr[2] == REG_ENDSTOP) endstop_in = pwdata[30:0];
         else                         stall_en_in = pwdata[0];
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               tgt_in   = POS_BITS'(tsat);
               // zero speed or accel runs as one
               spd_in   = (req_speed == '0) ? 32'd1 : req_speed;
               acc_in   = (req_accel == '0) ? 32'd1 : req_accel;
               tmp_t_in = req_now_ticks + req_start_delay_ticks;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            pulse_in = 1'b0;
            state_in = S_OUT;
            case (cmd_ff)
               CMD_START: state_in = S_PREP;
               CMD_ADVANCE: begin
                  if (pend_ff) begin
                     // the first event only marks the start of the move
                     if (step_ff != 33'd1) begin
                        pulse_in = 1'b1;
                        pos_in   = pos_ff + (dir_ff ? POS_BITS'(1) : {POS_BITS{1'b1}});
                     end
                     if (phase_ff <= PH_DECEL) begin
                        job_in   = J_PLAN;
                        state_in = S_JMUL;
                     end else begin
                        pend_in = 1'b0;
                     end
                  end
               end
               CMD_STOP: begin
                  phase_in = PH_STOP;
                  pend_in  = 1'b0;
               end
               default: begin
                  if (stall_en_ff) begin
                     phase_in = PH_STALL;
                     pend_in  = 1'b0;
                  end
               end
            endcase
         end
         S_PREP: begin
            dir_in   = diff > 33'sd0;
            d3_in    = diff[32] ? 32'(-diff) : diff[31:0];
            state_in = S_DIV_IS;
         end
         S_DIV_IS: begin
            if (div_done) begin
               inv_s_in = (div_quot > INV_S_MAX) ? INV_S_MAX[47:0] : div_quot[47:0];
               state_in = S_DIV_IA;
            end
         end
         S_DIV_IA: begin
            if (div_done) begin
               inv_ha_in = div_quot;
               state_in  = S_MUL_SQ;
            end
         end
         S_MUL_SQ: begin
            if (mul_done) state_in = S_DIV_D1;
         end
         S_DIV_D1: begin
            if (div_done) state_in = S_ADJ;
         end
         S_ADJ: begin
            // short moves split the distance in half
            if ({div_quot, 1'b0} < {33'd0, d3_ff}) begin
               d1_in = div_quot[31:0];
               d2_in = d3_ff - div_quot[31:0];
            end else begin
               d1_in = d3_ff >> 1;
               d2_in = d3_ff - (d3_ff >> 1);
            end
            t0_in    = tmp_t_ff;
            job_in   = J_T1;
            state_in = S_JMUL;
         end
         S_JMUL: begin
            if (mul_done) state_in = job_root ? S_JSQRT : S_JFIN;
         end
         S_JSQRT: begin
            if (sqrt_done) state_in = S_JFIN;
         end
         S_JFIN: begin
            state_in = S_JMUL;
            case (job_ff)
               J_T1: begin
                  t1_in  = t0_ff + job_r;
                  job_in = J_T2;
               end
               J_T2: begin
                  t2_in  = t1_ff + job_r;
                  job_in = J_T3;
               end
               J_T3: begin
                  t3_in    = t2_ff + job_r;
                  phase_in = PH_ACCEL;
                  step_in  = '0;
                  job_in   = J_PLAN;
               end
               default: begin
                  sched_in = plan_t;
                  pend_in  = 1'b1;
                  if (step_ff >= {1'b0, d3_ff})      phase_in = PH_STOP;
                  else if (step_ff == {1'b0, d2_ff}) phase_in = PH_DECEL;
                  else if (step_ff == {1'b0, d1_ff}) phase_in = PH_SLEW;
                  step_in  = step_ff + 33'd1;
                  state_in = S_OUT;
               end
            endcase
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ready_in = pend_ff;
               rsp_time_in  = pend_ff ? sched_ff : '1;
               rsp_phase_in = phase_ff;
               rsp_pulse_in = pulse_ff;
               rsp_dir_in   = dir_ff;
               rsp_pos_in   = 32'(pos_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // each unit gets one start pulse on entry to its state
      launch_in = (state_in != state_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         endstop_ff   <= 31'd65536;
         stall_en_ff  <= 1'b0;
         pos_ff       <= '0;
         phase_ff     <= PH_STOP;
         step_ff      <= '0;
         dir_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         pulse_ff     <= 1'b0;
         sched_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         endstop_ff   <= endstop_in;
         stall_en_ff  <= stall_en_in;
         pos_ff       <= pos_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         dir_ff       <= dir_in;
         pend_ff      <= pend_in;
         pulse_ff     <= pulse_in;
         sched_ff     <= sched_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff       <= job_in;
      cmd_ff       <= cmd_in;
      tgt_ff       <= tgt_in;
      spd_ff       <= spd_in;
      acc_ff       <= acc_in;
      tmp_t_ff     <= tmp_t_in;
      d1_ff        <= d1_in;
      d2_ff        <= d2_in;
      d3_ff        <= d3_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      t3_ff        <= t3_in;
      inv_s_ff     <= inv_s_in;
      inv_ha_ff    <= inv_ha_in;
      rsp_ready_ff <= rsp_ready_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   tsp_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .done (div_done), .quot (div_quot)
   );

   tsp_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .prod (mul_prod)
   );

   tsp_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sqrt_start),
      .rad (sqrt_rad), .done (sqrt_done), .root (sqrt_root)
   );

   // ports
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_due    = rsp_ready_ff;
   assign rsp_next_time   = rsp_time_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_step_pulse  = rsp_pulse_ff;
   assign rsp_direction   = rsp_dir_ff;
   assign rsp_position    = rsp_pos_ff;
   assign pready          = 1'b1;
   assign prdata          = (paddr[2] == REG_ENDSTOP) ? {1'b0, endstop_ff}
                                                      : {31'd0, stall_en_ff};
endmodule

FILE: rtl/tsp_checker.sv
// port-level checks for the step planner, bound to the top level
`timescale 1ns / 1ps
module tsp_port_props
   import tsp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_step_due,
   input logic [31:0] rsp_next_time,
   input logic [2:0]  rsp_phase,
   input logic        pready
);
   // a stalled response word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // no scheduled step means the all-ones time
   a_idle_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_step_due |-> rsp_next_time == 32'hFFFF_FFFF)
      else $error("next time without scheduled step");

   // a stalled axis never has a step pending
   a_stall_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_phase == PH_STALL |-> !rsp_step_due)
      else $error("step pending after stall");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port not ready");
endmodule

bind trapezoid_step_planner_core tsp_port_props u_tsp_port_props (.*);
